### src/smnce_pkg.sv
// Shared types, constants and table construction for the loss unit.
`default_nettype none
package smnce_pkg;

  localparam int MAX_ELEMENTS = 4096;
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int TALLY_W = $clog2(MAX_ELEMENTS + 1);
  localparam int LOGIT_W = 16;
  localparam int TARGET_W = 2;
  localparam int WEIGHT_W = 16;
  localparam int LOSS_W = 32;
  localparam int GRAD_W = 16;
  localparam int SUM_W = 40;
  localparam int MAXNEG_W = 24;
  localparam int TAB_W = 13;
  localparam int DIV_W = 48;
  localparam int DIVISOR_W = 18;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 80;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;
  localparam logic [TARGET_W-1:0] TARGET_NEG = 2'd0;
  localparam logic [TARGET_W-1:0] TARGET_POS = 2'd1;
  localparam logic [TARGET_W-1:0] TARGET_IGNORE = 2'd2;
  localparam logic [TARGET_W-1:0] TARGET_IGNORE_HI = 2'd3;
  localparam logic KIND_FORWARD = 1'b0;
  localparam logic KIND_BACKWARD = 1'b1;

  typedef struct packed {
    logic accept;
    logic mul;
    logic prep;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fwd_nonlast;
    logic bwd_inactive;
    logic div_last;
    logic out_free;
  } stat_t;

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // {sigmoid(a_k), softplus(-a_k)} in Q.12, a_k = k*8/entries
  function automatic logic [2*TAB_W-1:0] table_entry(input int k, input int entries);
    logic [63:0] one, a, y, p2, p3, p4, e, z, z2, term, sum, ln, sp, sig;
    one = 64'd1 << 30;
    a = udiv64(64'(k) << 33, 64'(entries));
    y = a >> 8;
    p2 = (y * y) >> 30;
    p3 = (p2 * y) >> 30;
    p4 = (p3 * y) >> 30;
    e = one - y + p2 / 2 - p3 / 6 + p4 / 24;
    for (int i = 0; i < 8; i++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    z = udiv64(e << 30, (64'd2 << 30) + e);
    z2 = (z * z) >> 30;
    term = z;
    sum = '0;
    for (int j = 1; j <= 21; j += 2) begin
      sum = sum + udiv64(term, 64'(j));
      term = (term * z2) >> 30;
    end
    ln = 2 * sum;
    sp = (ln + (64'd1 << 17)) >> 18;
    sig = (udiv64(64'd1 << 60, one + e) + (64'd1 << 17)) >> 18;
    return {sig[TAB_W-1:0], sp[TAB_W-1:0]};
  endfunction

endpackage
`default_nettype wire

### src/sigmoid_max_neg_cross_entropy_loss_unit.sv
// Top level of the sigmoid cross-entropy loss unit with hard negative mining.
// A forward element that is not marked last only updates the accumulators
// and yields no result. The last forward element and every backward element
// with a positive label or at the hard negative index go from acceptance
// through a multiply, operand preparation, 48 steps of the restoring divider,
// which retires one quotient bit per cycle, and a load of the output register,
// which waits for that register to be free. Other backward elements go straight
// from acceptance to that load. One element is in work at a time; a finished
// result waits in the output register while the next element is taken.
// Tables are constant logic, so there is no start-up pass after reset.
`default_nettype none
module sigmoid_max_neg_cross_entropy_loss_unit #(
  parameter int TABLE_ENTRIES = smnce_pkg::TABLE_ENTRIES
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // logit[15:0], target[17:16], zero[23:18]
  input  wire logic [smnce_pkg::IN_DATA_W-1:0]       s_tdata,
  // kind
  input  wire logic                                  s_tuser,
  input  wire logic                                  s_tlast,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // loss[31:0], gradient[47:32], hard_negative_index[59:48],
  // hard_negative_found[60], positive_count[73:61], zero[79:74]
  output logic [smnce_pkg::OUT_DATA_W-1:0]           m_tdata,
  // result_kind
  output logic                                       m_tuser,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [smnce_pkg::WEIGHT_W-1:0]        cfg_data
);

  smnce_pkg::cmd_t cmd;
  smnce_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  smnce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  smnce_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .kind      (s_tuser),
    .logit     (s_tdata[15:0]),
    .target    (s_tdata[17:16]),
    .last      (s_tlast),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_value (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_kind  (m_tuser),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

### src/smnce_ctrl.sv
// Sequencing state machine for the loss unit.
`default_nettype none
module smnce_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire smnce_pkg::stat_t stat,
  output smnce_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.fwd_nonlast) state_next = S_IDLE;
          else if (stat.bwd_inactive) state_next = S_DONE;
          else state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule
`default_nettype wire

### src/smnce_datapath.sv
// Accumulators, table lookup, multiplier, serial divider and output register.
`default_nettype none
module smnce_datapath #(
  parameter int TABLE_ENTRIES = smnce_pkg::TABLE_ENTRIES
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               kind,
  input  wire logic [smnce_pkg::LOGIT_W-1:0]      logit,
  input  wire logic [smnce_pkg::TARGET_W-1:0]     target,
  input  wire logic                               last,
  input  wire logic                               cfg_we,
  input  wire logic [smnce_pkg::WEIGHT_W-1:0]     cfg_value,
  input  wire smnce_pkg::cmd_t                    cmd,
  output smnce_pkg::stat_t                        stat,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic                                    out_kind,
  output logic [smnce_pkg::OUT_DATA_W-1:0]        out_data
);

  localparam int TIDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TW = smnce_pkg::TAB_W;
  localparam int IW = smnce_pkg::IDX_W;
  localparam int CW = smnce_pkg::TALLY_W;
  localparam int DW = smnce_pkg::DIV_W;
  localparam int VW = smnce_pkg::DIVISOR_W;
  localparam int SW = smnce_pkg::SUM_W;
  localparam int MW = smnce_pkg::MAXNEG_W;
  localparam int CNT_W = $clog2(DW);
  localparam logic [TW-1:0] Q12_ONE = TW'(4096);
  localparam logic [CW-1:0] TALLY_MAX = CW'(smnce_pkg::MAX_ELEMENTS);

  logic [TW-1:0] sp_tab [TABLE_ENTRIES];
  logic [TW-1:0] sig_tab [TABLE_ENTRIES];

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_tab
    localparam logic [2*TW-1:0] ENTRY = smnce_pkg::table_entry(k, TABLE_ENTRIES);
    assign sp_tab[k] = ENTRY[TW-1:0];
    assign sig_tab[k] = ENTRY[2*TW-1:TW];
  end

  logic [smnce_pkg::WEIGHT_W-1:0] grad_scale;
  logic [IW-1:0] elem_idx;
  logic [SW-1:0] pos_sum;
  logic [CW-1:0] pos_tally;
  logic [MW-1:0] max_neg;
  logic [IW-1:0] max_pos;
  logic neg_seen, fwd_open;

  logic is_grad, grad_neg, active;
  logic [TW-1:0] m_mag;
  logic [CW-1:0] numr;
  logic [25:0] prod1;
  logic [DW-1:0] quot;
  logic [VW-1:0] rem, divisor;
  logic [CNT_W-1:0] cnt;

  logic xneg;
  logic [16:0] mag;
  logic [31:0] tidx_full;
  logic [TIDX_W-1:0] tidx;
  logic [TW-1:0] sp, sig, dval;
  logic [16:0] l_pos, l_neg;
  logic [SW-1:0] base_sum;
  logic [CW-1:0] base_tally;
  logic [MW-1:0] base_max;
  logic [IW-1:0] base_pos, here;
  logic base_seen;
  logic [SW:0] sum_add;
  logic [SW-1:0] sum_next;
  logic [CW-1:0] tally_next;
  logic [MW-1:0] max_next;
  logic [IW-1:0] pos_next;
  logic seen_next;
  logic in_active, in_neg;
  logic [TW-1:0] in_mag;
  logic [CW-1:0] in_numr;

  always_comb begin
    xneg = logit[15];
    mag = xneg ? (17'd0 - {logit[15], logit}) : {1'b0, logit};
    tidx_full = (32'(mag) * 32'(TABLE_ENTRIES) + 32'd16384) >> 15;
    if (tidx_full >= 32'(TABLE_ENTRIES - 1)) tidx = TIDX_W'(TABLE_ENTRIES - 1);
    else tidx = tidx_full[TIDX_W-1:0];
    sp = sp_tab[tidx];
    sig = sig_tab[tidx];
    l_pos = (xneg ? mag : 17'd0) + 17'(sp);
    l_neg = (xneg ? 17'd0 : mag) + 17'(sp);
    base_sum = fwd_open ? pos_sum : '0;
    base_tally = fwd_open ? pos_tally : '0;
    base_max = fwd_open ? max_neg : '0;
    base_pos = fwd_open ? max_pos : '0;
    base_seen = fwd_open & neg_seen;
    if (kind == smnce_pkg::KIND_FORWARD) here = fwd_open ? elem_idx : '0;
    else here = fwd_open ? '0 : elem_idx;
    sum_add = {1'b0, base_sum} + (SW + 1)'(l_pos);
    sum_next = base_sum;
    tally_next = base_tally;
    max_next = base_max;
    pos_next = base_pos;
    seen_next = base_seen;
    if (target == smnce_pkg::TARGET_POS) begin
      sum_next = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
      if (base_tally < TALLY_MAX) tally_next = base_tally + CW'(1);
    end else if (target == smnce_pkg::TARGET_NEG) begin
      if (!base_seen || MW'(l_neg) > base_max) begin
        max_next = MW'(l_neg);
        pos_next = here;
        seen_next = 1'b1;
      end
    end
    dval = xneg ? (Q12_ONE - sig) : sig;
    in_active = 1'b0;
    in_neg = 1'b0;
    in_mag = dval;
    in_numr = pos_tally;
    if (target == smnce_pkg::TARGET_POS) begin
      in_active = 1'b1;
      in_neg = 1'b1;
      in_mag = Q12_ONE - dval;
      in_numr = CW'(1);
    end else if (target == smnce_pkg::TARGET_NEG && neg_seen && here == max_pos) begin
      in_active = 1'b1;
    end
  end

  assign stat.fwd_nonlast = (kind == smnce_pkg::KIND_FORWARD) && !last;
  assign stat.bwd_inactive = (kind == smnce_pkg::KIND_BACKWARD) && !in_active;
  assign stat.div_last = (cnt == CNT_W'(DW - 1));
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grad_scale <= smnce_pkg::WEIGHT_RESET;
      elem_idx <= '0;
      pos_sum <= '0;
      pos_tally <= '0;
      max_neg <= '0;
      max_pos <= '0;
      neg_seen <= 1'b0;
      fwd_open <= 1'b0;
    end else begin
      if (cfg_we) grad_scale <= cfg_value;
      if (cmd.accept) begin
        elem_idx <= last ? '0 : here + IW'(1);
        if (kind == smnce_pkg::KIND_FORWARD) begin
          fwd_open <= !last;
          pos_sum <= sum_next;
          pos_tally <= tally_next;
          max_neg <= max_next;
          max_pos <= pos_next;
          neg_seen <= seen_next;
        end else begin
          fwd_open <= 1'b0;
        end
      end
    end
  end

  logic [CW:0] n1;
  logic [DW-1:0] loss_num, grad_num;
  logic [VW:0] rtry;

  always_comb begin
    n1 = {1'b0, pos_tally} + (CW + 1)'(1);
    loss_num = ((DW'(pos_sum) + DW'(max_neg) * DW'(pos_tally)) << 4) + DW'(n1 >> 1);
    grad_num = DW'(prod1) * DW'(grad_scale) + (DW'(n1) << 4);
    rtry = {rem, quot[DW-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_grad <= kind;
      active <= in_active;
      grad_neg <= in_neg;
      m_mag <= in_mag;
      numr <= in_numr;
    end
    if (cmd.mul) prod1 <= 26'(m_mag) * 26'(numr);
    if (cmd.prep) begin
      quot <= is_grad ? grad_num : loss_num;
      divisor <= is_grad ? (VW'(n1) << 5) : VW'(n1);
      rem <= '0;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      cnt <= cnt + CNT_W'(1);
      if (rtry >= {1'b0, divisor}) begin
        rem <= VW'(rtry - {1'b0, divisor});
        quot <= {quot[DW-2:0], 1'b1};
      end else begin
        rem <= rtry[VW-1:0];
        quot <= {quot[DW-2:0], 1'b0};
      end
    end
  end

  logic [smnce_pkg::LOSS_W-1:0] loss_val;
  logic [smnce_pkg::GRAD_W-1:0] grad_val;

  always_comb begin
    loss_val = (|quot[DW-1:32]) ? '1 : quot[31:0];
    grad_val = '0;
    if (is_grad && active) begin
      if (grad_neg) grad_val = (quot > DW'(32768)) ? 16'h8000 : 16'(16'd0 - quot[15:0]);
      else grad_val = (quot > DW'(32767)) ? 16'h7fff : quot[15:0];
    end
    if (is_grad) loss_val = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind <= is_grad;
      out_data <= {6'd0, pos_tally, neg_seen, max_pos, grad_val, loss_val};
    end
  end

endmodule
`default_nettype wire

### src/smnce_checker.sv
// Port-level assertions for the loss unit, bound to the top level.
`default_nettype none
module smnce_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [smnce_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic                            m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_grad_no_loss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
    else $error("gradient transaction carries a loss");

  a_loss_no_grad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[47:32] == 16'd0)
    else $error("loss transaction carries a gradient");

  a_index_unfound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[60] |-> m_tdata[59:48] == 12'd0)
    else $error("hard negative index set with none found");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[73:61] <= 13'(smnce_pkg::MAX_ELEMENTS))
    else $error("positive count out of range");

endmodule

bind sigmoid_max_neg_cross_entropy_loss_unit smnce_checker u_smnce_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
